// ----- sv/dbms_pkg.sv -----
// dbms_pkg: types and the draw-order comparison shared by the sorter modules
// no dependencies
package dbms_pkg;

  localparam int unsigned DepthW = 32;
  localparam int unsigned LayerW = 8;
  localparam int unsigned IdW    = 16;

  // one stored draw batch, all sort keys plus the id
  typedef struct packed {
    logic              render_enabled;
    logic              refractive;
    logic [LayerW-1:0] draw_layer;
    logic              translucent;
    logic [DepthW-1:0] view_depth;
    logic [LayerW-1:0] effect_layer;
    logic [IdW-1:0]    shader_id;
    logic [IdW-1:0]    buffer_id;
    logic [IdW-1:0]    item_id;
  } item_t;

  // control broadcast along the cell row
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  // true if batch a is drawn strictly before batch b
  function automatic logic precedes(item_t a, item_t b);
    logic res;
    if (a.render_enabled != b.render_enabled) begin
      res = a.render_enabled;
    end else if (a.refractive != b.refractive) begin
      res = ~a.refractive;
    end else if (a.draw_layer != b.draw_layer) begin
      res = $signed(a.draw_layer) < $signed(b.draw_layer);
    end else if (a.translucent != b.translucent) begin
      res = ~a.translucent;
    end else if (a.translucent && (a.view_depth != b.view_depth)) begin
      res = $signed(a.view_depth) > $signed(b.view_depth);
    end else if (a.effect_layer != b.effect_layer) begin
      res = $signed(a.effect_layer) < $signed(b.effect_layer);
    end else if (a.shader_id != b.shader_id) begin
      res = a.shader_id < b.shader_id;
    end else if (a.buffer_id != b.buffer_id) begin
      res = a.buffer_id < b.buffer_id;
    end else if (!a.translucent && (a.view_depth != b.view_depth)) begin
      res = $signed(a.view_depth) < $signed(b.view_depth);
    end else begin
      res = a.item_id < b.item_id;
    end
    return res;
  endfunction

endpackage

// ----- sv/dbms_if.sv -----
// dbms_in_if / dbms_out_if: valid-ready channels for batches and sorted ids
// depends on dbms_pkg for field widths
interface dbms_in_if;
  logic                         valid;
  logic                         ready;
  logic                         render_enabled;
  logic                         refractive;
  logic [dbms_pkg::LayerW-1:0]  draw_layer;
  logic                         translucent;
  logic [dbms_pkg::DepthW-1:0]  view_depth;
  logic [dbms_pkg::LayerW-1:0]  effect_layer;
  logic [dbms_pkg::IdW-1:0]     shader_id;
  logic [dbms_pkg::IdW-1:0]     buffer_id;
  logic [dbms_pkg::IdW-1:0]     item_id;
  logic                         last_item;

  modport source (
    output valid, render_enabled, refractive, draw_layer, translucent, view_depth,
           effect_layer, shader_id, buffer_id, item_id, last_item,
    input  ready
  );
  modport sink (
    input  valid, render_enabled, refractive, draw_layer, translucent, view_depth,
           effect_layer, shader_id, buffer_id, item_id, last_item,
    output ready
  );
endinterface

interface dbms_out_if;
  logic                     valid;
  logic                     ready;
  logic [dbms_pkg::IdW-1:0] sorted_id;
  logic                     last_out;
  logic                     overflowed;

  modport source (output valid, sorted_id, last_out, overflowed, input ready);
  modport sink   (input valid, sorted_id, last_out, overflowed, output ready);
endinterface

// ----- sv/dbms_cell.sv -----
// dbms_cell: one slot of the insertion chain, holds a batch and its valid bit
// depends on dbms_pkg
module dbms_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dbms_pkg::cell_ctrl_t ctrl_i,
  input  dbms_pkg::item_t      new_item_i,
  input  dbms_pkg::item_t      prev_item_i,
  input  logic                 prev_valid_i,
  input  logic                 prev_prec_i,
  input  dbms_pkg::item_t      next_item_i,
  input  logic                 next_valid_i,
  output dbms_pkg::item_t      item_o,
  output logic                 valid_o,
  output logic                 prec_o
);

  dbms_pkg::item_t item_q, item_d;
  logic            valid_q, valid_d;

  // new batch goes in front of the batch held here
  assign prec_o = valid_q & dbms_pkg::precedes(new_item_i, item_q);

  always_comb begin
    item_d  = item_q;
    valid_d = valid_q;
    if (ctrl_i.pop) begin
      item_d  = next_item_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.ins) begin
      if (prev_prec_i) begin
        // make room: take the neighbour's batch
        item_d  = prev_item_i;
        valid_d = 1'b1;
      end else if (prec_o || (!valid_q && prev_valid_i)) begin
        item_d  = new_item_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

// ----- sv/draw_batch_multi_key_sorter.sv -----
// draw_batch_multi_key_sorter: insertion-chain sorter for draw batches
// fill: one batch beat per cycle, each cell compares itself with the new batch
// run: starts the cycle after the last-marked beat, one id per cycle unless stalled
// by order_o.ready, one id per stored batch; no batch beat is taken while the run is out
// reset: asynchronous active low, empties every cell and clears the overflow flag
// depends on dbms_pkg, dbms_in_if, dbms_out_if, dbms_cell
module draw_batch_multi_key_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dbms_in_if.sink    batch_i,
  dbms_out_if.source order_o
);

  dbms_pkg::item_t      new_item;
  dbms_pkg::item_t      cell_item [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_valid;
  logic [MAX_ITEMS-1:0] cell_prec;
  dbms_pkg::cell_ctrl_t ctrl;

  logic draining_q, draining_d;
  logic overflow_q, overflow_d;
  logic in_beat, out_beat, full;

  // pack the incoming beat into the stored form
  assign new_item.render_enabled = batch_i.render_enabled;
  assign new_item.refractive     = batch_i.refractive;
  assign new_item.draw_layer     = batch_i.draw_layer;
  assign new_item.translucent    = batch_i.translucent;
  assign new_item.view_depth     = batch_i.view_depth;
  assign new_item.effect_layer   = batch_i.effect_layer;
  assign new_item.shader_id      = batch_i.shader_id;
  assign new_item.buffer_id      = batch_i.buffer_id;
  assign new_item.item_id        = batch_i.item_id;

  // input side stalls only while the sorted run is going out
  assign batch_i.ready = ~draining_q;
  assign in_beat       = batch_i.valid & batch_i.ready;
  assign out_beat      = order_o.valid & order_o.ready;

  // the occupied cells always form a run from cell 0, so the top cell says full
  assign full = cell_valid[MAX_ITEMS-1];

  assign ctrl.ins = in_beat & ~full;
  assign ctrl.pop = out_beat;

  // the row of cells: insertion shifts towards the top, the run shifts to cell 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    dbms_pkg::item_t prev_item, next_item;
    logic            prev_valid, prev_prec, next_valid;

    if (i == 0) begin : g_head
      assign prev_item  = new_item;
      assign prev_valid = 1'b1;
      assign prev_prec  = 1'b0;
    end else begin : g_body
      assign prev_item  = cell_item[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_prec  = cell_prec[i-1];
    end

    if (i == MAX_ITEMS-1) begin : g_tail
      assign next_item  = new_item;
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_item  = cell_item[i+1];
      assign next_valid = cell_valid[i+1];
    end

    dbms_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_item_i   (new_item),
      .prev_item_i  (prev_item),
      .prev_valid_i (prev_valid),
      .prev_prec_i  (prev_prec),
      .next_item_i  (next_item),
      .next_valid_i (next_valid),
      .item_o       (cell_item[i]),
      .valid_o      (cell_valid[i]),
      .prec_o       (cell_prec[i])
    );
  end

  // the head cell is the output register of the run
  assign order_o.valid      = draining_q & cell_valid[0];
  assign order_o.sorted_id  = cell_item[0].item_id;
  assign order_o.last_out   = ~cell_valid[1];
  assign order_o.overflowed = overflow_q;

  always_comb begin
    draining_d = draining_q;
    overflow_d = overflow_q;
    if (in_beat) begin
      if (full) begin
        // no room: batch is dropped but a last mark still starts the run
        overflow_d = 1'b1;
      end
      if (batch_i.last_item) begin
        draining_d = 1'b1;
      end
    end
    if (out_beat && order_o.last_out) begin
      draining_d = 1'b0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      draining_q <= draining_d;
      overflow_q <= overflow_d;
    end
  end

  // occupied cells stay packed from cell 0 upwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + {{(MAX_ITEMS-1){1'b0}}, 1'b1}) & cell_valid) == '0)
    else $error("cell occupancy is not contiguous");

  // a run beat is never offered while batches are being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    order_o.valid |-> !batch_i.ready)
    else $error("run overlaps batch intake");

  // after the final id the store is empty and the flag is cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && order_o.last_out) |=> (cell_valid == '0 && !overflow_q && !order_o.valid))
    else $error("store not emptied after run");

  // while the run is out the head cell always holds a batch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> cell_valid[0])
    else $error("run with empty head cell");

endmodule
